@@ sv/hdf_pkg.sv @@
package hdf_pkg;

    // dump length limit in bytes
    localparam int MAX_BYTES  = 4095;
    localparam int POS_W      = $clog2(MAX_BYTES + 1);
    localparam int LINE_BYTES = 16;
    localparam int HALF_BYTES = 8;
    localparam int PREFIX_LEN = 8;
    localparam int SUB_W      = $clog2(PREFIX_LEN);

    function automatic int dec_digits(input int v);
        int n;
        int x;
        n = 1;
        x = v;
        while (x >= 10) begin
            x = x / 10;
            n = n + 1;
        end
        return n;
    endfunction

    localparam int MAX_LINE    = MAX_BYTES / LINE_BYTES;
    localparam int LINE_DIGITS = dec_digits(MAX_LINE);
    localparam int DIG_IDX_W   = (LINE_DIGITS > 1) ? $clog2(LINE_DIGITS) : 1;
    localparam int NDIG_W      = $clog2(LINE_DIGITS + 1);

    // command queue between front and back
    localparam int CMD_DEPTH = 2;
    localparam int CPTR_W    = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;

    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_NL       = 8'h0A;
    localparam logic [7:0] CH_SP       = 8'h20;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_ZERO     = 8'd48;
    localparam logic [7:0] HEX_UC_OFF  = 8'd55;
    localparam logic [7:0] HEX_LC_OFF  = 8'd87;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
    } t_in;

    typedef struct packed {
        logic [7:0] out_char;
        logic       end_of_run;
        logic       too_long;
    } t_out;

    typedef struct packed {
        logic                             err;
        logic                             nl;
        logic                             pre;
        logic                             gap;
        logic                             last;
        logic [7:0]                       data_byte;
        logic [LINE_DIGITS-1:0][3:0]      line_bcd;
        logic [NDIG_W-1:0]                ndig;
    } t_cmd;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_NL,
        PH_PRE,
        PH_GAP,
        PH_HI,
        PH_LO,
        PH_SP,
        PH_EOL,
        PH_TERM,
        PH_ERR
    } t_phase;

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic lower);
        logic [7:0] v;
        v = {4'd0, nib};
        if (nib <= 4'd9) begin
            return v + CH_ZERO;
        end
        return v + (lower ? HEX_LC_OFF : HEX_UC_OFF);
    endfunction

endpackage

@@ sv/hdf_front.sv @@
module hdf_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hdf_pkg::t_in  i_in,
    input  logic          i_cmd_full,
    output logic          o_full,
    output logic          o_cmd_push,
    output hdf_pkg::t_cmd o_cmd
);
    import hdf_pkg::*;

    logic [POS_W-1:0]            r_pos, n_pos;
    logic [LINE_DIGITS-1:0][3:0] r_bcd, n_bcd;
    logic [LINE_DIGITS-1:0][3:0] w_bcd_inc;
    logic                        w_acc;
    logic                        w_err;
    logic [3:0]                  w_col;

    assign o_full     = i_cmd_full;
    assign w_acc      = i_push && !i_cmd_full;
    assign o_cmd_push = w_acc;
    assign w_err      = r_pos >= POS_W'(MAX_BYTES);
    assign w_col      = r_pos[3:0];

    // decimal line counter, +1 with ripple carry
    always_comb begin
        logic carry;
        carry = 1'b1;
        for (int i = 0; i < LINE_DIGITS; i++) begin
            if (carry && r_bcd[i] == 4'd9) begin
                w_bcd_inc[i] = 4'd0;
            end else begin
                w_bcd_inc[i] = r_bcd[i] + {3'd0, carry};
                carry        = 1'b0;
            end
        end
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.err       = w_err;
        o_cmd.pre       = (w_col == 4'd0);
        o_cmd.nl        = (w_col == 4'd0) && (r_pos != '0);
        o_cmd.gap       = (w_col == 4'(HALF_BYTES));
        o_cmd.last      = i_in.is_last;
        o_cmd.data_byte = i_in.data_byte;
        o_cmd.line_bcd  = r_bcd;
        o_cmd.ndig      = NDIG_W'(1);
        for (int i = 1; i < LINE_DIGITS; i++) begin
            if (r_bcd[i] != 4'd0) begin
                o_cmd.ndig = NDIG_W'(i + 1);
            end
        end
    end

    always_comb begin
        n_pos = r_pos;
        n_bcd = r_bcd;
        if (w_acc) begin
            if (i_in.is_last) begin
                n_pos = '0;
                n_bcd = '0;
            end else if (!w_err) begin
                n_pos = r_pos + POS_W'(1);
                if (w_col == 4'(LINE_BYTES - 1)) begin
                    n_bcd = w_bcd_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_bcd <= '0;
        end else begin
            r_pos <= n_pos;
            r_bcd <= n_bcd;
        end
    end

endmodule

@@ sv/hdf_cmd_fifo.sv @@
module hdf_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hdf_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output hdf_pkg::t_cmd o_data,
    output logic          o_empty
);
    import hdf_pkg::*;

    t_cmd                r_mem [CMD_DEPTH];
    logic [CPTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CPTR_W:0]     r_count;
    logic                w_wr, w_rd;

    assign o_full  = (r_count == (CPTR_W + 1)'(CMD_DEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + CPTR_W'(1);
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + CPTR_W'(1);
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + (CPTR_W + 1)'(1);
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - (CPTR_W + 1)'(1);
            end
        end
    end

endmodule

@@ sv/hdf_back.sv @@
module hdf_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_lowercase,
    input  hdf_pkg::t_cmd i_cmd,
    input  logic          i_cmd_empty,
    output logic          o_cmd_pop,
    output hdf_pkg::t_out o_out,
    output logic          o_empty,
    input  logic          i_pop
);
    import hdf_pkg::*;

    t_phase           r_phase, n_phase;
    logic [SUB_W-1:0] r_sub, n_sub;
    t_cmd             r_cmd, n_cmd;
    t_out             r_out, n_out;
    logic             r_out_valid, n_out_valid;

    t_out             w_char;
    logic             w_final;
    t_phase           w_step_phase;
    logic [SUB_W-1:0] w_step_sub;
    logic [3:0]       w_didx;
    logic             w_adv;

    function automatic t_phase start_phase(input t_cmd c);
        if (c.err) begin
            return PH_ERR;
        end
        if (c.nl) begin
            return PH_NL;
        end
        if (c.pre) begin
            return PH_PRE;
        end
        if (c.gap) begin
            return PH_GAP;
        end
        return PH_HI;
    endfunction

    assign w_adv   = !r_out_valid || i_pop;
    assign w_didx  = 4'(r_cmd.ndig) - 4'd1 - 4'(r_sub);
    assign o_out   = r_out;
    assign o_empty = !r_out_valid;

    // character for the current phase
    always_comb begin
        w_char       = '0;
        w_final      = 1'b0;
        w_step_phase = r_phase;
        w_step_sub   = '0;
        case (r_phase)
            PH_NL: begin
                w_char.out_char = CH_NL;
                w_step_phase    = PH_PRE;
            end
            PH_PRE: begin
                if (4'(r_sub) < 4'(r_cmd.ndig)) begin
                    w_char.out_char = CH_ZERO
                        + {4'd0, r_cmd.line_bcd[w_didx[DIG_IDX_W-1:0]]};
                end else if (4'(r_sub) == 4'(r_cmd.ndig)) begin
                    w_char.out_char = CH_DOT;
                end else begin
                    w_char.out_char = CH_SP;
                end
                if (r_sub == SUB_W'(PREFIX_LEN - 1)) begin
                    w_step_phase = PH_HI;
                end else begin
                    w_step_sub = r_sub + SUB_W'(1);
                end
            end
            PH_GAP: begin
                w_char.out_char = CH_SP;
                if (r_sub == SUB_W'(1)) begin
                    w_step_phase = PH_HI;
                end else begin
                    w_step_sub = r_sub + SUB_W'(1);
                end
            end
            PH_HI: begin
                w_char.out_char = hex_char(r_cmd.data_byte[7:4], i_lowercase);
                w_step_phase    = PH_LO;
            end
            PH_LO: begin
                w_char.out_char = hex_char(r_cmd.data_byte[3:0], i_lowercase);
                w_step_phase    = PH_SP;
            end
            PH_SP: begin
                w_char.out_char   = CH_SP;
                w_final           = !r_cmd.last;
                w_char.end_of_run = !r_cmd.last;
                w_step_phase      = PH_EOL;
            end
            PH_EOL: begin
                w_char.out_char = CH_NL;
                w_step_phase    = PH_TERM;
            end
            PH_TERM: begin
                w_char.out_char   = CH_NUL;
                w_char.end_of_run = 1'b1;
                w_final           = 1'b1;
            end
            PH_ERR: begin
                w_char.out_char   = CH_NUL;
                w_char.end_of_run = 1'b1;
                w_char.too_long   = 1'b1;
                w_final           = 1'b1;
            end
            default: begin
                w_char = '0;
            end
        endcase
    end

    always_comb begin
        n_phase     = r_phase;
        n_sub       = r_sub;
        n_cmd       = r_cmd;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        o_cmd_pop   = 1'b0;
        if (r_phase == PH_IDLE) begin
            if (i_pop) begin
                n_out_valid = 1'b0;
            end
            if (!i_cmd_empty) begin
                n_cmd     = i_cmd;
                n_phase   = start_phase(i_cmd);
                n_sub     = '0;
                o_cmd_pop = 1'b1;
            end
        end else if (w_adv) begin
            n_out       = w_char;
            n_out_valid = 1'b1;
            if (w_final) begin
                // chain straight into the next command, no bubble
                if (!i_cmd_empty) begin
                    n_cmd     = i_cmd;
                    n_phase   = start_phase(i_cmd);
                    n_sub     = '0;
                    o_cmd_pop = 1'b1;
                end else begin
                    n_phase = PH_IDLE;
                end
            end else begin
                n_phase = w_step_phase;
                n_sub   = w_step_sub;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sub <= n_sub;
        r_cmd <= n_cmd;
        r_out <= n_out;
    end

endmodule

@@ sv/hex_dump_formatter_core.sv @@
// Streaming hex dump: bytes go in through a queue-style port (push/full) and
// ASCII characters come out one per beat (empty/pop), 16 bytes per line, each
// line opened by an 8-character decimal line-number prefix, a double space
// before the second half, and a newline plus zero terminator after the byte
// flagged is_last. Bytes past MAX_BYTES in one dump give a single too_long
// beat instead of text. A byte makes 3 characters in the usual case, 5 at
// the half-line gap, 11 or 12 at a line start, plus 2 for the closing
// newline and terminator; the one-character-per-cycle output register holds
// its character while pop is low. The front takes a byte every cycle into
// a two-entry command queue, so the input only stalls once that queue is
// full, and the back moves from one queued command to the next without going idle.
module hex_dump_formatter_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // byte input
    input  logic          push,
    output logic          full,
    input  hdf_pkg::t_in  i_in,
    // character output
    output logic          empty,
    input  logic          pop,
    output hdf_pkg::t_out o_out,
    // lowercase_hex register
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata
);
    import hdf_pkg::*;

    logic r_lowercase;

    // front -> queue
    logic w_cmd_push;
    t_cmd w_cmd_in;
    logic w_cmd_full;
    // queue -> back
    t_cmd w_cmd_out;
    logic w_cmd_empty;
    logic w_cmd_pop;

    // the user changes the register only while idle (not enforced here); the back reads it live
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lowercase <= 1'b0;
        end else if (i_cfg_we) begin
            r_lowercase <= i_cfg_wdata;
        end
    end

    // classify each byte: error, newline, prefix, half gap, last
    hdf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_in       (i_in),
        .i_cmd_full (w_cmd_full),
        .o_full     (full),
        .o_cmd_push (w_cmd_push),
        .o_cmd      (w_cmd_in)
    );

    // decouples byte intake from character output
    hdf_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_data  (w_cmd_in),
        .o_full  (w_cmd_full),
        .i_pop   (w_cmd_pop),
        .o_data  (w_cmd_out),
        .o_empty (w_cmd_empty)
    );

    // one character per beat from the output register
    hdf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_lowercase (r_lowercase),
        .i_cmd       (w_cmd_out),
        .i_cmd_empty (w_cmd_empty),
        .o_cmd_pop   (w_cmd_pop),
        .o_out       (o_out),
        .o_empty     (empty),
        .i_pop       (pop)
    );

endmodule

@@ sv/hdf_checker.sv @@
module hdf_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          empty,
    input logic          pop,
    input hdf_pkg::t_out o_out
);
    import hdf_pkg::*;

    // nothing to read right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("output not empty after reset");

    // refused byte: single beat, zero char, closes the run
    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out.too_long) |-> (o_out.end_of_run && o_out.out_char == CH_NUL))
        else $error("too_long beat malformed");

    // a zero char is only ever a terminator or a too_long beat, and ends the run
    a_term_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out.out_char == CH_NUL) |-> o_out.end_of_run)
        else $error("zero char without end_of_run");

    // stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out)))
        else $error("output changed while stalled");

endmodule

bind hex_dump_formatter_core hdf_checker u_hdf_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .empty   (empty),
    .pop     (pop),
    .o_out   (o_out)
);

@@ test/hex_dump_formatter_core_tb.sv @@
`timescale 1ns / 100ps

module hex_dump_formatter_core_tb;

    import hdf_pkg::*;

    // cycles without any accepted beat before the run is called hung
    localparam int STALL_LIMIT   = 2000;
    // receiver back-pressure stretch, and the beat count that triggers it
    localparam int HOLD_CYCLES   = 150;
    localparam int HOLD_AT_BEAT  = 300;
    localparam int RANDOM_ITEMS  = 380;
    // drain time after the last expected beat
    localparam int TAIL_CYCLES   = 20;

    // kinds of rows in the directed table
    typedef enum logic [2:0] {
        ROW_PREDICT,   // expectation from the predictor
        ROW_TEXT,      // expectation typed in as text (+ NUL when closing)
        ROW_TOO_LONG,  // expectation is the single length-error beat
        ROW_FILL,      // random non-closing bytes until the dump is full
        ROW_CFG        // idle, then write lowercase_hex from data[0]
    } t_row_kind;

    typedef struct packed {
        t_row_kind  kind;
        logic [7:0] data;
        logic       last;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;
    logic push;
    logic full;
    t_in  i_in;
    logic empty;
    logic pop;
    t_out o_out;
    logic i_cfg_we;
    logic i_cfg_wdata;

    hex_dump_formatter_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in        (i_in),
        .empty       (empty),
        .pop         (pop),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // predictor state: bytes so far in the open dump, and the case register
    logic [POS_W-1:0] dump_pos;
    logic             hex_lower;

    // character beats still owed by the block, oldest first
    t_out expected_beats[$];
    // beats of the item being sent: from the predictor, or typed in
    t_out fresh_beats[$];
    t_out typed_beats[$];

    t_dir_row dir_rows[$];
    string    dir_text[$];

    // both sides stop idling while this is set
    logic steady;
    int   mismatch_count;
    int   beats_seen;

    function automatic logic [7:0] nibble_ascii(input logic [3:0] nib);
        if (nib < 4'd10) begin
            return CH_ZERO + {4'd0, nib};
        end
        return (hex_lower ? HEX_LC_OFF : HEX_UC_OFF) + {4'd0, nib};
    endfunction

    // Work out the text beats one byte causes and advance the dump position.
    task automatic format_byte(input logic [7:0] b, input logic l);
        logic [7:0]  chars[$];
        int unsigned digs[$];
        int unsigned line_no;
        int          pre_len;
        t_out        beat;
        fresh_beats = {};
        // dump already at the limit: one error beat, no text
        if (dump_pos >= MAX_BYTES) begin
            beat = '{out_char: CH_NUL, end_of_run: 1'b1, too_long: 1'b1};
            fresh_beats.push_back(beat);
            // a refused closing byte still ends the dump, without NL/NUL
            if (l) begin
                dump_pos = '0;
            end
            return;
        end
        if (dump_pos % LINE_BYTES == 0) begin
            if (dump_pos != 0) begin
                chars.push_back(CH_NL);
            end
            // decimal line number, '.', then spaces out to the prefix width
            line_no = dump_pos / LINE_BYTES;
            do begin
                digs.push_front(line_no % 10);
                line_no = line_no / 10;
            end while (line_no != 0);
            foreach (digs[i]) begin
                chars.push_back(CH_ZERO + 8'(digs[i]));
            end
            chars.push_back(CH_DOT);
            pre_len = digs.size() + 1;
            while (pre_len < PREFIX_LEN) begin
                chars.push_back(CH_SP);
                pre_len++;
            end
        end else if (dump_pos % HALF_BYTES == 0) begin
            // double space opens the second half of the line
            chars.push_back(CH_SP);
            chars.push_back(CH_SP);
        end
        chars.push_back(nibble_ascii(b[7:4]));
        chars.push_back(nibble_ascii(b[3:0]));
        chars.push_back(CH_SP);
        if (l) begin
            chars.push_back(CH_NL);
            chars.push_back(CH_NUL);
            dump_pos = '0;
        end else begin
            dump_pos = dump_pos + 1'b1;
        end
        foreach (chars[i]) begin
            beat = '{out_char: chars[i], end_of_run: (i == chars.size() - 1), too_long: 1'b0};
            fresh_beats.push_back(beat);
        end
    endtask

    // Typed expectation: the text, a NUL when the byte closes the dump.
    task automatic text_beats(input string s, input logic l);
        t_out beat;
        typed_beats = {};
        for (int i = 0; i < s.len(); i++) begin
            beat = '{out_char: s[i], end_of_run: 1'b0, too_long: 1'b0};
            typed_beats.push_back(beat);
        end
        if (l) begin
            beat = '{out_char: CH_NUL, end_of_run: 1'b0, too_long: 1'b0};
            typed_beats.push_back(beat);
        end
        typed_beats[typed_beats.size() - 1].end_of_run = 1'b1;
    endtask

    // Offer one byte, wait for the push beat, then queue what it owes.
    // push is left high so back-to-back bytes need no gap.
    task automatic send_item(input logic [7:0] b, input logic l);
        while (!steady && $urandom_range(0, 99) < 16) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_in <= '{data_byte: b, is_last: l};
        do begin
            @(posedge i_clk);
        end while (full);
        // predictor always runs so its position tracks typed rows too
        format_byte(b, l);
        if (typed_beats.size() != 0) begin
            foreach (typed_beats[i]) begin
                expected_beats.push_back(typed_beats[i]);
            end
            typed_beats = {};
        end else begin
            foreach (fresh_beats[i]) begin
                expected_beats.push_back(fresh_beats[i]);
            end
        end
    endtask

    // Register write only once the block owes nothing more.
    task automatic write_hex_case(input logic v);
        push <= 1'b0;
        @(posedge i_clk);
        while (expected_beats.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        hex_lower = v;
    endtask

    task automatic add_row(input t_row_kind k, input logic [7:0] d, input logic l,
                           input string s);
        dir_rows.push_back('{kind: k, data: d, last: l});
        dir_text.push_back(s);
    endtask

    task automatic check_beat(input t_out got);
        t_out want;
        beats_seen++;
        if (expected_beats.size() == 0) begin
            $error("unexpected beat: out_char %h end_of_run %b too_long %b",
                   got.out_char, got.end_of_run, got.too_long);
            mismatch_count++;
            return;
        end
        want = expected_beats.pop_front();
        if (got.out_char !== want.out_char) begin
            $error("out_char: expected %h, got %h", want.out_char, got.out_char);
            mismatch_count++;
        end
        if (got.end_of_run !== want.end_of_run) begin
            $error("end_of_run: expected %b, got %b", want.end_of_run, got.end_of_run);
            mismatch_count++;
        end
        if (got.too_long !== want.too_long) begin
            $error("too_long: expected %b, got %b", want.too_long, got.too_long);
            mismatch_count++;
        end
    endtask

    // Receiver: pops at random, and once holds off long enough that the
    // command queue fills and full pushes back on the sender.
    initial begin
        logic hold_done;
        hold_done = 1'b0;
        pop <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) begin
            @(posedge i_clk);
        end
        forever begin
            if (!hold_done && beats_seen >= HOLD_AT_BEAT) begin
                hold_done = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            pop <= !(!steady && $urandom_range(0, 99) < 16);
            @(posedge i_clk);
            if (pop && !empty) begin
                check_beat(o_out);
            end
        end
    end

    // Watchdog: any accepted beat on either side restarts the count.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (push && !full) || (pop && !empty)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("** hex_dump_formatter_core: FAILED **");
        $finish;
    end

    initial begin
        int        total;
        int        len;
        int        pick;
        logic      ragged;
        logic      l;
        t_dir_row  row;

        push        <= 1'b0;
        i_in        <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= 1'b0;
        i_rst_n     <= 1'b0;
        steady         = 1'b0;
        mismatch_count = 0;
        beats_seen     = 0;
        dump_pos       = '0;
        hex_lower      = 1'b0;

        // Directed table. Typed rows: single-byte dumps right after a close,
        // byte extremes in both cases, and the length-error beats.
        add_row(ROW_TEXT, 8'h00, 1'b1, "0.      00 \n");
        add_row(ROW_TEXT, 8'hFF, 1'b1, "0.      FF \n");
        // 17-byte dump: half-line gap at byte 8, second line prefix at 16
        for (int k = 0; k < 17; k++) begin
            add_row(ROW_PREDICT, 8'(k * 8'h1F), (k == 16), "");
        end
        add_row(ROW_CFG,  8'h01, 1'b0, "");
        add_row(ROW_TEXT, 8'hAB, 1'b1, "0.      ab \n");
        add_row(ROW_TEXT, 8'hFF, 1'b1, "0.      ff \n");
        // fill a dump to the limit; then bytes are refused, a refused
        // closing byte clears the position without NL/NUL
        add_row(ROW_FILL,     8'h00, 1'b0, "");
        add_row(ROW_TOO_LONG, 8'h00, 1'b0, "");
        add_row(ROW_TOO_LONG, 8'hFF, 1'b0, "");
        add_row(ROW_TOO_LONG, 8'h80, 1'b1, "");
        add_row(ROW_CFG,  8'h00, 1'b0, "");
        add_row(ROW_TEXT, 8'h0F, 1'b1, "0.      0F \n");

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            case (row.kind)
                ROW_CFG: begin
                    write_hex_case(row.data[0]);
                end
                ROW_FILL: begin
                    while (dump_pos < MAX_BYTES) begin
                        send_item(8'($urandom_range(0, 255)), 1'b0);
                    end
                end
                ROW_TOO_LONG: begin
                    typed_beats = {};
                    typed_beats.push_back('{out_char: CH_NUL, end_of_run: 1'b1,
                                            too_long: 1'b1});
                    send_item(row.data, row.last);
                end
                ROW_TEXT: begin
                    text_beats(dir_text[i], row.last);
                    send_item(row.data, row.last);
                end
                default: begin
                    send_item(row.data, row.last);
                end
            endcase
        end

        // Random dumps: mostly short, some long enough for several lines.
        // A few are ragged, closing at a random byte. Register flips only
        // between dumps, with the block drained.
        total = 0;
        while (total < RANDOM_ITEMS) begin
            if ($urandom_range(0, 99) < 20) begin
                write_hex_case(1'($urandom_range(0, 1)));
            end
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                len = $urandom_range(1, 20);
            end else if (pick < 95) begin
                len = $urandom_range(21, 60);
            end else begin
                len = $urandom_range(61, 130);
            end
            ragged = ($urandom_range(0, 99) < 10);
            for (int k = 0; k < len; k++) begin
                steady = (total >= 120 && total < 220);
                l = (k == len - 1) || (ragged && $urandom_range(0, 99) < 15);
                send_item(8'($urandom_range(0, 255)), l);
                total++;
                if (l) begin
                    break;
                end
            end
        end
        steady = 1'b0;
        push <= 1'b0;

        while (expected_beats.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("** hex_dump_formatter_core: PASSED **");
        end else begin
            $display("** hex_dump_formatter_core: FAILED **");
        end
        $finish;
    end

endmodule
